[sv/string_literal_escape_encoder_unit_macros.svh]
// ============================================================================
// String literal escape encoder - assertion macros
// Shared property wrappers for the checker file.
// ============================================================================
`ifndef STRING_LITERAL_ESCAPE_ENCODER_UNIT_MACROS_SVH
`define STRING_LITERAL_ESCAPE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define SLEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is held
`define SLEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked through reset as well
`define SLEE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/slee_pkg.sv]
// ============================================================================
// String literal escape encoder - package
// ASCII constants and the escape letter lookup.
// ============================================================================
`default_nettype none

package slee_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_SEVEN     = 8'h37;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;

    // Control bytes and quote bytes with single-character escapes
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_DQ  = 8'h22;
    localparam logic [7:0] BYTE_SQ  = 8'h27;

    // Index of the final character of each escape form
    localparam logic [1:0] LAST_PLAIN  = 2'd0;
    localparam logic [1:0] LAST_LETTER = 2'd1;
    localparam logic [1:0] LAST_OCTAL  = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [7:0] letter;
    } slee_letter_t;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= CHAR_ZERO && b <= CHAR_NINE) ||
               (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
               (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
    endfunction

    // Letter escape for a byte; bell and vertical tab only in C mode
    function automatic slee_letter_t escape_letter(input logic [7:0] b,
                                                   input logic       java);
        slee_letter_t res;
        res.hit    = 1'b1;
        res.letter = 8'h00;
        unique case (b)
            BYTE_LF:  res.letter = "n";
            BYTE_CR:  res.letter = "r";
            BYTE_BS:  res.letter = "b";
            BYTE_FF:  res.letter = "f";
            BYTE_TAB: res.letter = "t";
            BYTE_SQ:  res.letter = 8'h27;
            BYTE_DQ:  res.letter = 8'h22;
            BYTE_BEL: begin
                res.hit    = !java;
                res.letter = "a";
            end
            BYTE_VT: begin
                res.hit    = !java;
                res.letter = "v";
            end
            default:  res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/string_literal_escape_encoder_unit.sv]
// Path: an accepted byte enters the item register, and each of its characters then passes through the output register.
// Output: 1 character per letter or digit, 2 per letter escape, 4 per octal
// escape; the output register issues one character per cycle unless stalled.
// Reset: aresetn (synchronous, active low) empties both registers and sets
// java_mode to C escapes.
// ============================================================================
// String literal escape encoder
// Expands each byte into its C or Java string literal form, one character
// per output item.
// ============================================================================
`default_nettype none

module string_literal_escape_encoder_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_java_mode,
    // input bytes
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    // escaped characters
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_is_last
);
    import slee_pkg::*;

    logic         java_mode_reg;
    logic         item_valid_reg, item_valid_next;
    logic [7:0]   item_byte_reg,  item_byte_next;
    logic [1:0]   idx_reg,        idx_next;
    logic         m_valid_reg,    m_valid_next;
    logic [7:0]   m_char_reg,     m_char_next;
    logic         m_last_reg,     m_last_next;

    slee_letter_t esc;
    logic [1:0]   last_idx;
    logic [7:0]   cur_char;
    logic         out_load;
    logic         item_done;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            java_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            java_mode_reg <= cfg_java_mode;
        end
    end

    // Classify the held byte and pick the character at the current index
    always_comb begin
        esc      = escape_letter(item_byte_reg, java_mode_reg);
        cur_char = CHAR_BACKSLASH;
        if (is_alnum(item_byte_reg)) begin
            last_idx = LAST_PLAIN;
            cur_char = item_byte_reg;
        end else if (esc.hit) begin
            last_idx = LAST_LETTER;
            if (idx_reg != 2'd0) begin
                cur_char = esc.letter;
            end
        end else begin
            last_idx = LAST_OCTAL;
            case (idx_reg)
                2'd1:    cur_char = CHAR_ZERO | {6'd0, item_byte_reg[7:6]};
                2'd2:    cur_char = CHAR_ZERO | {5'd0, item_byte_reg[5:3]};
                2'd3:    cur_char = CHAR_ZERO | {5'd0, item_byte_reg[2:0]};
                default: cur_char = CHAR_BACKSLASH;
            endcase
        end
    end

    // Handshake: hold byte until its last character enters the output register
    assign out_load  = item_valid_reg && (!m_valid_reg || m_ready);
    assign item_done = out_load && (idx_reg == last_idx);
    assign s_ready   = !item_valid_reg || item_done;

    always_comb begin
        item_valid_next = item_valid_reg;
        item_byte_next  = item_byte_reg;
        idx_next        = idx_reg;
        if (s_valid && s_ready) begin
            item_valid_next = 1'b1;
            item_byte_next  = s_in_byte;
            idx_next        = 2'd0;
        end else if (item_done) begin
            item_valid_next = 1'b0;
            idx_next        = 2'd0;
        end else if (out_load) begin
            idx_next        = idx_reg + 2'd1;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_char_next  = cur_char;
            m_last_next  = (idx_reg == last_idx);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_byte_reg <= item_byte_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_is_last  = m_last_reg;

endmodule

`default_nettype wire

[sv/slee_checker.sv]
// ============================================================================
// String literal escape encoder - port checker
// Watches the top level's ports and flags malformed output sequences.
// ============================================================================
`default_nettype none

`include "string_literal_escape_encoder_unit_macros.svh"

module slee_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_char,
    input wire logic       m_is_last
);
    import slee_pkg::*;

    // Output is empty straight after reset
    `SLEE_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // A stalled item holds its character and flag
    `SLEE_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_char) && $stable(m_is_last))

    // Only a backslash or an octal digit can open or continue an escape
    `SLEE_ASSERT_NOW(a_mid_char, aclk, aresetn, m_valid && !m_is_last, m_out_char == CHAR_BACKSLASH || (m_out_char >= CHAR_ZERO && m_out_char <= CHAR_SEVEN))

    // A byte never ends on a bare backslash
    `SLEE_ASSERT_NOW(a_last_char, aclk, aresetn, m_valid && m_is_last, m_out_char != CHAR_BACKSLASH)

endmodule

bind string_literal_escape_encoder_unit slee_checker u_slee_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_char (m_out_char),
    .m_is_last  (m_is_last)
);

`default_nettype wire
